[hdl/daq_pkg.sv]
// ----------------------------------------------------------------------------
// Ancestor query package
// Shared constants, controller state type and the command and status words
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package daq_pkg;

  localparam int DEF_MAX_EDGES   = 131072;
  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_ID_BITS     = 24;

  localparam int CNT_W = 18;  // width of the edge count register
  localparam int IDX_W = 17;  // width of the load index field

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CHK      = 10'b00_0000_0010,
    ST_BS_REQ   = 10'b00_0000_0100,
    ST_BS_CMP   = 10'b00_0000_1000,
    ST_RUN_REQ  = 10'b00_0001_0000,
    ST_RUN_CMP  = 10'b00_0010_0000,
    ST_FR_REQ   = 10'b00_0100_0000,
    ST_FR_CMP   = 10'b00_1000_0000,
    ST_POP      = 10'b01_0000_0000,
    ST_POP_WAIT = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic load_wr;    // write one edge from the input ports
    logic q_latch;    // capture query term and candidate
    logic bs_init;    // start a search for the query term
    logic bs_rd;      // read the middle entry of the search window
    logic bs_upd;     // narrow the search window
    logic run_rd;     // read the entry at the lower bound
    logic frm_init;   // make the first frame from the found run
    logic push;       // push the current frame and enter the found run
    logic fr_rd;      // read the entry at the frame position
    logic descend;    // step the frame and search for the parent
    logic pop_rd;     // read the frame below the top
    logic pop_load;   // load that frame as the top
    logic finish;     // deliver the answer
    logic res_anc;
    logic res_ovf;
  } cmd_t;

  typedef struct packed {
    logic term_bad;
    logic len_zero;
    logic less;
    logic low_ge_n;
    logic child_eq_key;
    logic key_eq_anc;
    logic idx_ge_n;
    logic child_eq_org;
    logic par_eq_anc;
    logic top_full;
    logic top_one;
  } stat_t;

endpackage

[hdl/daq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module daq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/daq_ctrl.sv]
// ----------------------------------------------------------------------------
// Ancestor query controller
// Sequences loads, binary searches, frame checks, pushes and pops.
// ----------------------------------------------------------------------------
module daq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_opcode,
  input  daq_pkg::stat_t stat,
  output daq_pkg::cmd_t  cmd,
  output logic           busy
);
  import daq_pkg::*;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.q_latch = 1'b1;
            state_nxt   = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (stat.term_bad) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.bs_init = 1'b1;
          first_nxt   = 1'b1;
          state_nxt   = ST_BS_REQ;
        end
      end
      ST_BS_REQ: begin
        if (stat.len_zero) begin
          state_nxt = ST_RUN_REQ;
        end else begin
          cmd.bs_rd = 1'b1;
          state_nxt = ST_BS_CMP;
        end
      end
      ST_BS_CMP: begin
        cmd.bs_upd = 1'b1;
        state_nxt  = ST_BS_REQ;
      end
      ST_RUN_REQ: begin
        if (stat.low_ge_n) begin
          if (first_r) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_FR_REQ;
          end
        end else begin
          cmd.run_rd = 1'b1;
          state_nxt  = ST_RUN_CMP;
        end
      end
      ST_RUN_CMP: begin
        if (!stat.child_eq_key) begin
          if (first_r) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_FR_REQ;
          end
        end else if (stat.key_eq_anc) begin
          cmd.finish  = 1'b1;
          cmd.res_anc = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (first_r) begin
          cmd.frm_init = 1'b1;
          first_nxt    = 1'b0;
          state_nxt    = ST_FR_REQ;
        end else if (stat.top_full) begin
          cmd.finish  = 1'b1;
          cmd.res_ovf = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = ST_FR_REQ;
        end
      end
      ST_FR_REQ: begin
        if (stat.idx_ge_n) begin
          state_nxt = ST_POP;
        end else begin
          cmd.fr_rd = 1'b1;
          state_nxt = ST_FR_CMP;
        end
      end
      ST_FR_CMP: begin
        if (!stat.child_eq_org) begin
          state_nxt = ST_POP;
        end else if (stat.par_eq_anc) begin
          cmd.finish  = 1'b1;
          cmd.res_anc = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = ST_BS_REQ;
        end
      end
      ST_POP: begin
        if (stat.top_one) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_FR_REQ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/daq_dp.sv]
// ----------------------------------------------------------------------------
// Ancestor query datapath
// Edge table, search window, top frame, frame stack and answer registers.
// ----------------------------------------------------------------------------
module daq_dp #(
  parameter int MAX_EDGES   = daq_pkg::DEF_MAX_EDGES,
  parameter int STACK_DEPTH = daq_pkg::DEF_STACK_DEPTH,
  parameter int ID_BITS     = daq_pkg::DEF_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  daq_pkg::cmd_t             cmd,
  output daq_pkg::stat_t            stat,
  input  logic                      cfg_we,
  input  logic [daq_pkg::CNT_W-1:0] cfg_data,
  input  logic [daq_pkg::IDX_W-1:0] in_edge_index,
  input  logic [ID_BITS-1:0]        in_edge_child,
  input  logic [ID_BITS-1:0]        in_edge_parent,
  input  logic [ID_BITS-1:0]        in_query_term,
  input  logic [ID_BITS-1:0]        in_query_ancestor,
  output logic                      out_valid,
  output logic                      out_is_ancestor,
  output logic                      out_status
);
  import daq_pkg::*;

  localparam int AW  = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int TW  = $clog2(STACK_DEPTH + 1);
  localparam int FW  = CW + ID_BITS;

  logic [CNT_W-1:0]   count_r;
  logic [CW-1:0]      n;
  logic [ID_BITS-1:0] term_r, anc_r, key_r, org_r;
  logic [CW-1:0]      low_r, len_r, idx_r, half, mid;
  logic [TW-1:0]      top_r;
  logic               out_valid_r, out_anc_r, out_ovf_r;

  logic               tbl_we;
  logic [AW-1:0]      tbl_addr;
  logic [2*ID_BITS-1:0] tbl_wdata, tbl_rdata;
  logic [ID_BITS-1:0] rd_child, rd_par;

  logic               stk_we;
  logic [SW-1:0]      stk_addr;
  logic [FW-1:0]      stk_wdata, stk_rdata;

  always_comb begin
    if (32'(count_r) > 32'(MAX_EDGES)) begin
      n = CW'(MAX_EDGES);
    end else begin
      n = CW'(count_r);
    end
  end

  assign half = len_r >> 1;
  assign mid  = low_r + half;

  // Edge table: child id in the upper half, parent id in the lower half.
  assign tbl_we    = cmd.load_wr && (32'(in_edge_index) < 32'(MAX_EDGES));
  assign tbl_wdata = {in_edge_child, in_edge_parent};
  always_comb begin
    if (cmd.load_wr) begin
      tbl_addr = AW'(in_edge_index);
    end else if (cmd.bs_rd) begin
      tbl_addr = mid[AW-1:0];
    end else if (cmd.run_rd) begin
      tbl_addr = low_r[AW-1:0];
    end else begin
      tbl_addr = idx_r[AW-1:0];
    end
  end
  assign rd_child = tbl_rdata[2*ID_BITS-1:ID_BITS];
  assign rd_par   = tbl_rdata[ID_BITS-1:0];

  daq_ram #(.WIDTH(2 * ID_BITS), .DEPTH(MAX_EDGES)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  // Frames below the top; the top frame lives in idx_r and org_r.
  assign stk_we    = cmd.push;
  assign stk_wdata = {idx_r, org_r};
  assign stk_addr  = cmd.push ? SW'(top_r - TW'(1)) : SW'(top_r - TW'(2));

  daq_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        top_r <= '0;
      end else if (cmd.frm_init) begin
        top_r <= TW'(1);
      end else if (cmd.push) begin
        top_r <= top_r + TW'(1);
      end else if (cmd.pop_rd) begin
        top_r <= top_r - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      term_r <= in_query_term;
      anc_r  <= in_query_ancestor;
    end
    if (cmd.bs_init) begin
      key_r <= term_r;
      low_r <= '0;
      len_r <= n;
    end else if (cmd.descend) begin
      key_r <= rd_par;
      low_r <= '0;
      len_r <= n;
    end else if (cmd.bs_upd) begin
      if (stat.less) begin
        low_r <= mid + CW'(1);
        len_r <= len_r - half - CW'(1);
      end else begin
        len_r <= half;
      end
    end
    if (cmd.frm_init || cmd.push) begin
      idx_r <= low_r;
      org_r <= key_r;
    end else if (cmd.descend) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.pop_load) begin
      idx_r <= stk_rdata[FW-1:ID_BITS];
      org_r <= stk_rdata[ID_BITS-1:0];
    end
    if (cmd.finish) begin
      out_anc_r <= cmd.res_anc;
      out_ovf_r <= cmd.res_ovf;
    end
  end

  assign stat.term_bad     = (term_r == '0) || (anc_r == '0);
  assign stat.len_zero     = (len_r == '0);
  assign stat.less         = (rd_child < key_r);
  assign stat.low_ge_n     = (low_r >= n);
  assign stat.child_eq_key = (rd_child == key_r);
  assign stat.key_eq_anc   = (key_r == anc_r);
  assign stat.idx_ge_n     = (idx_r >= n);
  assign stat.child_eq_org = (rd_child == org_r);
  assign stat.par_eq_anc   = (rd_par == anc_r);
  assign stat.top_full     = (32'(top_r) >= 32'(STACK_DEPTH));
  assign stat.top_one      = (top_r == TW'(1));

  assign out_valid       = out_valid_r;
  assign out_is_ancestor = out_anc_r;
  assign out_status      = out_ovf_r;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) <= 32'(STACK_DEPTH))
    else $error("frame stack beyond its depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (32'(top_r) < 32'(STACK_DEPTH)) && (top_r != '0))
    else $error("push without room or without a top frame");
  a_pop_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> (32'(top_r) >= 32'd2))
    else $error("pop read with no frame below the top");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid && (top_r == '0))
    else $error("answer not delivered or stack not emptied");
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_is_ancestor)
    else $error("overflow answer must be zero");

endmodule

[hdl/dag_ancestor_query.sv]
// ----------------------------------------------------------------------------
// DAG ancestor query
// Holds a child-to-parent edge table sorted by child id and answers whether
// a candidate id is reached from a term by a depth-first walk.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                    Handshake
//  -------   ---------------------------------------  -------------------------
//  input     in_opcode, in_edge_*, in_query_*         start high, busy low
//  result    out_is_ancestor, out_status              out_valid, one cycle
//  config    cfg_data (edge count)                    cfg_we, no wait
//
// A load word is written at the accepting edge and busy stays low. A query
// word first checks its ids. Each binary search then reads and compares the
// middle entry of the window once per halving, then reads and tests the run
// it lands on; each frame step reads and tests one entry, and a pop reads the
// frame below the top and loads it before the next frame step. The edge table
// has a single read port, so these steps run one after another and the total
// depends on how many terms the walk visits. The answer appears on out_valid
// for exactly one cycle, the first cycle in which busy is low again; the
// receiver cannot stall it. Reset is synchronous and clears the edge count,
// the stack pointer and the controller; the edge table is not cleared and
// needs no clearing pass, since only entries below the edge count are read.
//
// Each frame of the walk holds a position in a run of edges and the child id
// of that run. The top frame lives in registers; frames beneath it go to a
// small stack RAM. A push onto a full stack ends the query with the answer
// forced to zero and out_status set.
//
module dag_ancestor_query #(
  parameter int MAX_EDGES   = daq_pkg::DEF_MAX_EDGES,
  parameter int STACK_DEPTH = daq_pkg::DEF_STACK_DEPTH,
  parameter int ID_BITS     = daq_pkg::DEF_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic [daq_pkg::IDX_W-1:0] in_edge_index,
  input  logic [ID_BITS-1:0]        in_edge_child,
  input  logic [ID_BITS-1:0]        in_edge_parent,
  input  logic [ID_BITS-1:0]        in_query_term,
  input  logic [ID_BITS-1:0]        in_query_ancestor,
  output logic                      out_valid,
  output logic                      out_is_ancestor,
  output logic                      out_status,
  input  logic                      cfg_we,
  input  logic [daq_pkg::CNT_W-1:0] cfg_data
);
  import daq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller only ever sees the opcode; all payload goes to the datapath.
  daq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  daq_dp #(
    .MAX_EDGES   (MAX_EDGES),
    .STACK_DEPTH (STACK_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_edge_index     (in_edge_index),
    .in_edge_child     (in_edge_child),
    .in_edge_parent    (in_edge_parent),
    .in_query_term     (in_query_term),
    .in_query_ancestor (in_query_ancestor),
    .out_valid         (out_valid),
    .out_is_ancestor   (out_is_ancestor),
    .out_status        (out_status)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Ancestor query testbench
// Loads edge tables, sets the edge count and sends ancestor queries to the
// block. A predictor in the testbench walks its own copy of the table; each
// answer word is checked against it or against the answer typed in its row.
// ----------------------------------------------------------------------------
module tb;
  import daq_pkg::*;

  localparam int TAB_SIZE  = 131072;
  localparam int STK_DEPTH = 32;
  localparam int WD_LIMIT  = 1000000;

  typedef enum {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    bit [16:0]   idx;
    bit [23:0]   a;      // child id, query term or edge count
    bit [23:0]   b;      // parent id or candidate ancestor
    bit          typed;  // expected answer given in the row
    bit          ea;
    bit          es;
  } row_t;

  typedef struct {
    bit is_anc;
    bit ovf;
  } answer_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_opcode;
  logic [IDX_W-1:0]     in_edge_index;
  logic [23:0]          in_edge_child;
  logic [23:0]          in_edge_parent;
  logic [23:0]          in_query_term;
  logic [23:0]          in_query_ancestor;
  logic                 out_valid;
  logic                 out_is_ancestor;
  logic                 out_status;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_data;

  dag_ancestor_query uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_edge_index(in_edge_index),
    .in_edge_child(in_edge_child), .in_edge_parent(in_edge_parent),
    .in_query_term(in_query_term), .in_query_ancestor(in_query_ancestor),
    .out_valid(out_valid), .out_is_ancestor(out_is_ancestor),
    .out_status(out_status), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predictor state: our own copy of the edge table, count and walk stack.
  bit [23:0]      child_tab [TAB_SIZE];
  bit [23:0]      parent_tab[TAB_SIZE];
  bit [CNT_W-1:0] edge_count;
  bit [17:0]      frame_pos[STK_DEPTH];
  bit [23:0]      frame_org[STK_DEPTH];

  answer_t        answer_q[$];
  row_t           rows[$];
  int             mismatches;
  int             idle_cycles;
  int             burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Lower-bound search followed by a check that the run really starts there.
  function automatic bit run_start(bit [23:0] id, int n, output int pos);
    int lo, len, half;
    lo = 0;
    len = n;
    pos = 0;
    while (len > 0) begin
      half = len / 2;
      if (child_tab[lo + half] < id) begin
        lo = lo + half + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    if (n == 0 || lo >= n || child_tab[lo] != id) return 1'b0;
    pos = lo;
    return 1'b1;
  endfunction

  // Depth-first ancestor walk with an explicit stack of bounded depth.
  function automatic answer_t ancestor_walk(bit [23:0] term, bit [23:0] anc);
    answer_t r;
    int n, p, top, f, i;
    bit [23:0] par;
    r = '{0, 0};
    n = (edge_count > TAB_SIZE) ? TAB_SIZE : int'(edge_count);
    if (term == 0 || anc == 0) return r;
    if (!run_start(term, n, p)) return r;
    if (child_tab[p] == anc) begin
      r.is_anc = 1'b1;
      return r;
    end
    frame_pos[0] = p;
    frame_org[0] = child_tab[p];
    top = 1;
    while (top > 0) begin
      f = top - 1;
      i = frame_pos[f];
      if (i >= n || child_tab[i] != frame_org[f]) begin
        top--;
        continue;
      end
      par = parent_tab[i];
      if (par == anc) begin
        r.is_anc = 1'b1;
        return r;
      end
      frame_pos[f] = i + 1;
      if (!run_start(par, n, p)) continue;
      if (child_tab[p] == anc) begin
        r.is_anc = 1'b1;
        return r;
      end
      if (top >= STK_DEPTH) begin
        r.ovf = 1'b1;
        return r;
      end
      frame_pos[top] = p;
      frame_org[top] = par;
      top++;
    end
    return r;
  endfunction

  // Drives one word at the falling edge and holds it until it is taken. A
  // query pushes its answer, either the typed one or the predicted one.
  task automatic send_word(logic op, bit [16:0] idx, bit [23:0] a, bit [23:0] b,
                           bit typed = 0, bit ea = 0, bit es = 0);
    @(negedge clk);
    start             <= 1'b1;
    in_opcode         <= op;
    in_edge_index     <= idx;
    in_edge_child     <= a;
    in_edge_parent    <= b;
    in_query_term     <= (op == OP_QUERY) ? a : 24'($urandom);
    in_query_ancestor <= (op == OP_QUERY) ? b : 24'($urandom);
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      child_tab[idx]  = a;
      parent_tab[idx] = b;
    end else if (typed) begin
      answer_q.push_back('{ea, es});
    end else begin
      answer_q.push_back(ancestor_walk(a, b));
    end
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Sender pacing: bursts of random length with random gaps between them.
  task automatic pace();
    if (burst_left == 0) begin
      idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // The count is only changed once every answer is in and the block is idle.
  task automatic set_count(bit [CNT_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (answer_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= CNT_W'($urandom);
    edge_count = value;
  endtask

  task automatic add_row(row_kind_t k, bit [16:0] idx, bit [23:0] a, bit [23:0] b,
                         bit typed = 0, bit ea = 0, bit es = 0);
    rows.push_back('{k, idx, a, b, typed, ea, es});
  endtask

  // Random graph over a sorted pool of ids, mostly acyclic, sometimes a long
  // chain deeper than the stack, sometimes with back edges that close cycles.
  task automatic random_phase();
    bit [23:0] pool[$];
    int        ec[$];
    int        ep[$];
    bit [23:0] v, t, a;
    int        k, n, c, j, tmp, mode;
    mode = $urandom_range(0, 9);
    k = (mode == 0) ? 36 : $urandom_range(2, 20);
    while (pool.size() < k) begin
      v = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(1, 64));
      if (v == 0) continue;
      j = 0;
      while (j < pool.size() && pool[j] < v) j++;
      if (j < pool.size() && pool[j] == v) continue;
      pool.insert(j, v);
    end
    if (mode == 0) begin
      for (int i = 0; i < k - 1; i++) begin
        ec.push_back(i);
        ep.push_back(i + 1);
      end
    end else begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        c = $urandom_range(0, k - 2);
        ec.push_back(c);
        ep.push_back((mode == 1) ? $urandom_range(0, k - 1) : $urandom_range(c + 1, k - 1));
      end
      for (int i = 1; i < ec.size(); i++)
        for (int m = i; m > 0 && ec[m - 1] > ec[m]; m--) begin
          tmp = ec[m]; ec[m] = ec[m - 1]; ec[m - 1] = tmp;
          tmp = ep[m]; ep[m] = ep[m - 1]; ep[m - 1] = tmp;
        end
    end
    n = ec.size();
    for (int i = 0; i < n; i++) begin
      pace();
      send_word(OP_LOAD, 17'(i), pool[ec[i]], pool[ep[i]]);
    end
    set_count(($urandom_range(0, 5) == 0) ? CNT_W'($urandom_range(0, n)) : CNT_W'(n));
    repeat ($urandom_range(20, 40)) begin
      pace();
      if ($urandom_range(0, 9) == 0) begin
        send_word(OP_LOAD, 17'($urandom_range(n, TAB_SIZE - 1)), 24'($urandom),
                  24'($urandom));
        continue;
      end
      case ($urandom_range(0, 9))
        0:       t = 24'($urandom);
        1:       t = 24'h0;
        default: t = pool[$urandom_range(0, k - 1)];
      endcase
      case ($urandom_range(0, 9))
        0:       a = 24'($urandom);
        1:       a = 24'h0;
        2:       a = t;
        default: a = pool[$urandom_range(0, k - 1)];
      endcase
      send_word(OP_QUERY, 17'($urandom), t, a);
    end
  endtask

  // Answer checking at the rising edge.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer word: is_ancestor=%0b status=%0b",
                   out_is_ancestor, out_status);
      end else begin
        e = answer_q.pop_front();
        if (out_is_ancestor !== e.is_anc || out_status !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: expected is_ancestor=%0b status=%0b, got %0b %0b",
                     e.is_anc, e.ovf, out_is_ancestor, out_status);
        end
      end
    end
  end

  // Watchdog: cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t r;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    edge_count  = '0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = OP_LOAD;
    in_edge_index     = '0;
    in_edge_child     = '0;
    in_edge_parent    = '0;
    in_query_term     = '0;
    in_query_ancestor = '0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The table 5->7, 5->9, 7->11, 9->11, 11->max is acyclic
    // with five entries; a sixth entry max->5 closes a loop through the term.
    add_row(ROW_QUERY, 0, 24'd5, 24'd7, 1, 0, 0);          // empty table
    add_row(ROW_LOAD, 0, 24'd5, 24'd7);
    add_row(ROW_LOAD, 1, 24'd5, 24'd9);
    add_row(ROW_LOAD, 2, 24'd7, 24'd11);
    add_row(ROW_LOAD, 3, 24'd9, 24'd11);
    add_row(ROW_LOAD, 4, 24'd11, 24'hFFFFFF);
    add_row(ROW_LOAD, 5, 24'hFFFFFF, 24'd5);
    add_row(ROW_LOAD, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF);  // top index, not read
    add_row(ROW_COUNT, 0, 24'd5, 0);
    add_row(ROW_QUERY, 0, 24'd5, 24'd7, 1, 1, 0);          // direct parent
    add_row(ROW_QUERY, 0, 24'd5, 24'hFFFFFF, 1, 1, 0);     // deep ancestor
    add_row(ROW_QUERY, 0, 24'd5, 24'd5, 1, 1, 0);          // term itself
    add_row(ROW_QUERY, 0, 24'd11, 24'd5, 1, 0, 0);         // descendant
    add_row(ROW_QUERY, 0, 24'd0, 24'd7, 1, 0, 0);          // invalid term
    add_row(ROW_QUERY, 0, 24'd5, 24'd0, 1, 0, 0);          // invalid candidate
    add_row(ROW_QUERY, 0, 24'd3, 24'd3, 1, 0, 0);          // absent term
    add_row(ROW_QUERY, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0); // beyond the count
    add_row(ROW_QUERY, 0, 24'd9, 24'd4, 0);
    add_row(ROW_COUNT, 0, 24'd6, 0);
    add_row(ROW_QUERY, 0, 24'd5, 24'd3, 1, 0, 1);          // cycle overflows
    add_row(ROW_QUERY, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 1, 0);
    add_row(ROW_QUERY, 0, 24'd7, 24'd9, 0);
    add_row(ROW_COUNT, 0, 24'd0, 0);
    add_row(ROW_QUERY, 0, 24'd5, 24'd5, 1, 0, 0);
    foreach (rows[i]) begin
      r = rows[i];
      case (r.kind)
        ROW_LOAD:  send_word(OP_LOAD, r.idx, r.a, r.b);
        ROW_QUERY: send_word(OP_QUERY, r.idx, r.a, r.b, r.typed, r.ea, r.es);
        default:   set_count(CNT_W'(r.a));
      endcase
    end

    // Random graphs, each followed by a burst of queries.
    repeat (32) random_phase();

    @(negedge clk);
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
